FILE: rtl/console_line_discipline_defines.svh
// assertion macros for the console line discipline rtl
// no dependencies; included by files that carry concurrent assertions
`ifndef CONSOLE_LINE_DISCIPLINE_DEFINES_SVH
`define CONSOLE_LINE_DISCIPLINE_DEFINES_SVH

// same-cycle implication, disabled while reset is held
`define CLD_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("console line discipline: implication check failed");

// next-cycle implication, disabled while reset is held
`define CLD_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("console line discipline: next-cycle check failed");

`endif

FILE: rtl/cld_pkg.sv
// shared types, codes and helpers for the console line discipline
// no dependencies; used by cld_ctrl, cld_datapath and the top level
package cld_pkg;

    // result kinds
    localparam logic [2:0] KIND_ECHO = 3'd0;
    localparam logic [2:0] KIND_LINE = 3'd1;
    localparam logic [2:0] KIND_END  = 3'd2;
    localparam logic [2:0] KIND_QUIT = 3'd3;
    localparam logic [2:0] KIND_RAW  = 3'd4;

    localparam int KIND_W = 3;
    localparam int BYTE_W = 8;
    localparam int LEN_W  = 6;

    // control bytes
    localparam logic [7:0] KEY_NUL   = 8'h00;
    localparam logic [7:0] KEY_EOF   = 8'h04;
    localparam logic [7:0] KEY_BS    = 8'h08;
    localparam logic [7:0] KEY_LF    = 8'h0a;
    localparam logic [7:0] KEY_CR    = 8'h0d;
    localparam logic [7:0] KEY_KILL  = 8'h15;
    localparam logic [7:0] KEY_QUIT  = 8'h1c;
    localparam logic [7:0] KEY_DEL   = 8'h7f;

    // echo bytes
    localparam logic [7:0] ECHO_SPACE = 8'h20;
    localparam logic [7:0] ECHO_CARET = 8'h5e;
    localparam logic [7:0] ECHO_U     = 8'h55;

    typedef enum logic [2:0] {
        CLS_NUL,
        CLS_ERASE,
        CLS_KILL,
        CLS_QUIT,
        CLS_EOF,
        CLS_NEWLINE,
        CLS_OTHER
    } key_class_t;

    typedef enum logic [3:0] {
        EMIT_KEY,
        EMIT_BS,
        EMIT_SPACE,
        EMIT_CARET,
        EMIT_U,
        EMIT_NL,
        EMIT_LINE,
        EMIT_END,
        EMIT_QUIT,
        EMIT_RAW
    } emit_sel_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_ECHO,
        ST_ERASE_BS1,
        ST_ERASE_SP,
        ST_ERASE_BS2,
        ST_KILL_CARET,
        ST_KILL_U,
        ST_KILL_NL,
        ST_QUIT,
        ST_RAW,
        ST_LINE_START,
        ST_LINE,
        ST_END
    } ctrl_state_t;

    // controller to datapath
    typedef struct packed {
        logic      ready;
        logic      capture;
        logic      store;
        logic      fill_dec;
        logic      fill_clear;
        logic      rd_start;
        logic      rd_next;
        logic      emit;
        emit_sel_t sel;
        logic      last;
    } cld_cmd_t;

    // datapath to controller
    typedef struct packed {
        key_class_t cls;
        logic       raw;
        logic       fill_zero;
        logic       store_fills;
        logic       rd_done;
        logic       slot_free;
    } cld_stat_t;

    function automatic key_class_t classify_key(input logic [7:0] b);
        key_class_t cls;
        unique case (b) inside
            KEY_NUL:         cls = CLS_NUL;
            KEY_DEL, KEY_BS: cls = CLS_ERASE;
            KEY_KILL:        cls = CLS_KILL;
            KEY_QUIT:        cls = CLS_QUIT;
            KEY_EOF:         cls = CLS_EOF;
            KEY_CR, KEY_LF:  cls = CLS_NEWLINE;
            default:         cls = CLS_OTHER;
        endcase
        return cls;
    endfunction

endpackage

FILE: rtl/cld_ctrl.sv
// sequencing state machine of the console line discipline
// depends on cld_pkg for state, command and status types
module cld_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    input  cld_pkg::cld_stat_t stat,
    output cld_pkg::cld_cmd_t  cmd
);

    cld_pkg::ctrl_state_t state_reg, state_next;
    logic                 commit_reg, commit_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= cld_pkg::ST_IDLE;
            commit_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            commit_reg <= commit_next;
        end
    end

    // next state
    always_comb begin
        state_next  = state_reg;
        commit_next = commit_reg;
        unique case (state_reg)
            cld_pkg::ST_IDLE: begin
                if (in_valid) state_next = cld_pkg::ST_DECODE;
            end
            cld_pkg::ST_DECODE: begin
                commit_next = 1'b0;
                if (stat.raw) begin
                    state_next = cld_pkg::ST_RAW;
                end else begin
                    unique case (stat.cls)
                        cld_pkg::CLS_ERASE:
                            state_next = stat.fill_zero ? cld_pkg::ST_IDLE
                                                        : cld_pkg::ST_ERASE_BS1;
                        cld_pkg::CLS_KILL: state_next = cld_pkg::ST_KILL_CARET;
                        cld_pkg::CLS_QUIT: state_next = cld_pkg::ST_QUIT;
                        cld_pkg::CLS_EOF:  state_next = cld_pkg::ST_LINE_START;
                        cld_pkg::CLS_NUL:
                            state_next = stat.fill_zero ? cld_pkg::ST_IDLE
                                                        : cld_pkg::ST_LINE_START;
                        default: begin
                            state_next  = cld_pkg::ST_ECHO;
                            commit_next = (stat.cls == cld_pkg::CLS_NEWLINE)
                                          || stat.store_fills;
                        end
                    endcase
                end
            end
            cld_pkg::ST_ECHO: begin
                if (stat.slot_free)
                    state_next = commit_reg ? cld_pkg::ST_LINE_START : cld_pkg::ST_IDLE;
            end
            cld_pkg::ST_ERASE_BS1: if (stat.slot_free) state_next = cld_pkg::ST_ERASE_SP;
            cld_pkg::ST_ERASE_SP:  if (stat.slot_free) state_next = cld_pkg::ST_ERASE_BS2;
            cld_pkg::ST_ERASE_BS2: if (stat.slot_free) state_next = cld_pkg::ST_IDLE;
            cld_pkg::ST_KILL_CARET: if (stat.slot_free) state_next = cld_pkg::ST_KILL_U;
            cld_pkg::ST_KILL_U:     if (stat.slot_free) state_next = cld_pkg::ST_KILL_NL;
            cld_pkg::ST_KILL_NL:    if (stat.slot_free) state_next = cld_pkg::ST_IDLE;
            cld_pkg::ST_QUIT: if (stat.slot_free) state_next = cld_pkg::ST_IDLE;
            cld_pkg::ST_RAW:  if (stat.slot_free) state_next = cld_pkg::ST_IDLE;
            cld_pkg::ST_LINE_START: begin
                state_next = stat.fill_zero ? cld_pkg::ST_END : cld_pkg::ST_LINE;
            end
            cld_pkg::ST_LINE: begin
                if (stat.slot_free && stat.rd_done) state_next = cld_pkg::ST_END;
            end
            cld_pkg::ST_END: if (stat.slot_free) state_next = cld_pkg::ST_IDLE;
            default: state_next = cld_pkg::ST_IDLE;
        endcase
    end

    // commands
    always_comb begin
        cmd = '{ready: 1'b0, capture: 1'b0, store: 1'b0, fill_dec: 1'b0,
                fill_clear: 1'b0, rd_start: 1'b0, rd_next: 1'b0, emit: 1'b0,
                sel: cld_pkg::EMIT_KEY, last: 1'b0};
        unique case (state_reg)
            cld_pkg::ST_IDLE: begin
                cmd.ready   = 1'b1;
                cmd.capture = in_valid;
            end
            cld_pkg::ST_DECODE: begin
                if (!stat.raw) begin
                    unique case (stat.cls) inside
                        cld_pkg::CLS_ERASE: cmd.fill_dec = !stat.fill_zero;
                        cld_pkg::CLS_KILL:  cmd.fill_clear = 1'b1;
                        cld_pkg::CLS_NEWLINE, cld_pkg::CLS_OTHER: cmd.store = 1'b1;
                        default: ;
                    endcase
                end
            end
            cld_pkg::ST_ECHO: begin
                cmd.emit = stat.slot_free;
                cmd.sel  = cld_pkg::EMIT_KEY;
                cmd.last = !commit_reg;
            end
            cld_pkg::ST_ERASE_BS1: begin
                cmd.emit = stat.slot_free;
                cmd.sel  = cld_pkg::EMIT_BS;
            end
            cld_pkg::ST_ERASE_SP: begin
                cmd.emit = stat.slot_free;
                cmd.sel  = cld_pkg::EMIT_SPACE;
            end
            cld_pkg::ST_ERASE_BS2: begin
                cmd.emit = stat.slot_free;
                cmd.sel  = cld_pkg::EMIT_BS;
                cmd.last = 1'b1;
            end
            cld_pkg::ST_KILL_CARET: begin
                cmd.emit = stat.slot_free;
                cmd.sel  = cld_pkg::EMIT_CARET;
            end
            cld_pkg::ST_KILL_U: begin
                cmd.emit = stat.slot_free;
                cmd.sel  = cld_pkg::EMIT_U;
            end
            cld_pkg::ST_KILL_NL: begin
                cmd.emit = stat.slot_free;
                cmd.sel  = cld_pkg::EMIT_NL;
                cmd.last = 1'b1;
            end
            cld_pkg::ST_QUIT: begin
                cmd.emit = stat.slot_free;
                cmd.sel  = cld_pkg::EMIT_QUIT;
                cmd.last = 1'b1;
            end
            cld_pkg::ST_RAW: begin
                cmd.emit = stat.slot_free;
                cmd.sel  = cld_pkg::EMIT_RAW;
                cmd.last = 1'b1;
            end
            cld_pkg::ST_LINE_START: begin
                cmd.rd_start = 1'b1;
            end
            cld_pkg::ST_LINE: begin
                cmd.emit    = stat.slot_free;
                cmd.rd_next = stat.slot_free;
                cmd.sel     = cld_pkg::EMIT_LINE;
            end
            cld_pkg::ST_END: begin
                cmd.emit       = stat.slot_free;
                cmd.fill_clear = stat.slot_free;
                cmd.sel        = cld_pkg::EMIT_END;
                cmd.last       = 1'b1;
            end
            default: ;
        endcase
    end

endmodule

FILE: rtl/cld_datapath.sv
// line store, fill index, mode register and output register
// depends on cld_pkg; driven by commands from cld_ctrl
module cld_datapath #(
    parameter int LINE_BYTES = 32
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic [7:0]               key_in,
    input  logic                     cfg_we,
    input  logic                     cfg_raw,
    input  cld_pkg::cld_cmd_t         cmd,
    output cld_pkg::cld_stat_t        stat,
    input  logic                     out_ready,
    output logic                     out_valid,
    output logic [cld_pkg::KIND_W-1:0] out_kind,
    output logic [cld_pkg::BYTE_W-1:0] out_data,
    output logic [cld_pkg::LEN_W-1:0]  out_len,
    output logic                     out_last
);

    localparam int IDX_W  = $clog2(LINE_BYTES);
    localparam int FILL_W = $clog2(LINE_BYTES + 1);

    logic [7:0]        line_mem [LINE_BYTES];
    logic [7:0]        rd_data_reg;
    logic [IDX_W-1:0]  rd_idx_reg, rd_idx_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic              raw_reg;
    logic [7:0]        key_reg;
    logic [7:0]        key_mapped;

    logic                       m_valid_reg;
    logic [cld_pkg::KIND_W-1:0] m_kind_reg, m_kind_next;
    logic [cld_pkg::BYTE_W-1:0] m_data_reg, m_data_next;
    logic [cld_pkg::LEN_W-1:0]  m_len_reg, m_len_next;
    logic                       m_last_reg;

    // carriage return is stored and echoed as newline
    assign key_mapped = (key_reg == cld_pkg::KEY_CR) ? cld_pkg::KEY_LF : key_reg;

    always_comb begin
        fill_next = fill_reg;
        if (cmd.fill_clear)    fill_next = '0;
        else if (cmd.fill_dec) fill_next = fill_reg - FILL_W'(1);
        else if (cmd.store)    fill_next = fill_reg + FILL_W'(1);
    end

    always_comb begin
        rd_idx_next = rd_idx_reg;
        if (cmd.rd_start)     rd_idx_next = '0;
        else if (cmd.rd_next) rd_idx_next = rd_idx_reg + IDX_W'(1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg    <= '0;
            raw_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            fill_reg <= fill_next;
            if (cfg_we) raw_reg <= cfg_raw;
            if (cmd.emit)       m_valid_reg <= 1'b1;
            else if (out_ready) m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        rd_idx_reg <= rd_idx_next;
        if (cmd.capture) key_reg <= key_in;
        if (cmd.emit) begin
            m_kind_reg <= m_kind_next;
            m_data_reg <= m_data_next;
            m_len_reg  <= m_len_next;
            m_last_reg <= cmd.last;
        end
    end

    // line store, one write and one registered read port
    always_ff @(posedge aclk) begin
        if (cmd.store) line_mem[fill_reg[IDX_W-1:0]] <= key_mapped;
        rd_data_reg <= line_mem[rd_idx_next];
    end

    always_comb begin
        m_kind_next = cld_pkg::KIND_ECHO;
        m_data_next = '0;
        m_len_next  = '0;
        unique case (cmd.sel)
            cld_pkg::EMIT_KEY:   m_data_next = key_mapped;
            cld_pkg::EMIT_BS:    m_data_next = cld_pkg::KEY_BS;
            cld_pkg::EMIT_SPACE: m_data_next = cld_pkg::ECHO_SPACE;
            cld_pkg::EMIT_CARET: m_data_next = cld_pkg::ECHO_CARET;
            cld_pkg::EMIT_U:     m_data_next = cld_pkg::ECHO_U;
            cld_pkg::EMIT_NL:    m_data_next = cld_pkg::KEY_LF;
            cld_pkg::EMIT_LINE: begin
                m_kind_next = cld_pkg::KIND_LINE;
                m_data_next = rd_data_reg;
            end
            cld_pkg::EMIT_END: begin
                m_kind_next = cld_pkg::KIND_END;
                m_len_next  = cld_pkg::LEN_W'(fill_reg);
            end
            cld_pkg::EMIT_QUIT: m_kind_next = cld_pkg::KIND_QUIT;
            cld_pkg::EMIT_RAW: begin
                m_kind_next = cld_pkg::KIND_RAW;
                m_data_next = key_reg;
            end
            default: ;
        endcase
    end

    assign stat.cls         = cld_pkg::classify_key(key_reg);
    assign stat.raw         = raw_reg;
    assign stat.fill_zero   = (fill_reg == '0);
    assign stat.store_fills = ((fill_reg + FILL_W'(1)) == FILL_W'(LINE_BYTES));
    assign stat.rd_done     = ((FILL_W'(rd_idx_reg) + FILL_W'(1)) == fill_reg);
    assign stat.slot_free   = !m_valid_reg || out_ready;

    assign out_valid = m_valid_reg;
    assign out_kind  = m_kind_reg;
    assign out_data  = m_data_reg;
    assign out_len   = m_len_reg;
    assign out_last  = m_last_reg;

endmodule

FILE: rtl/console_line_discipline.sv
// console line discipline: one key byte per input beat, results as output beats
// an item is accepted, then decoded, then sends one output beat per result while the
// output is free; an item that commits a line first passes a start state for the line
// store read to prime; worst case is the byte that fills the line, with LINE_BYTES + 2
// results; a raw byte is accepted, decoded and sent as a single raw result
// aresetn (synchronous, active low) empties the line, clears raw mode and the output
// depends on cld_pkg, cld_ctrl, cld_datapath and console_line_discipline_defines.svh
`include "console_line_discipline_defines.svh"

module console_line_discipline #(
    parameter int LINE_BYTES = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] key_byte
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] data_byte, [13:8] line_length, [15:14] zero
    output logic [2:0]  m_tuser,   // [2:0] kind
    output logic        m_tlast,   // last beat caused by this input
    // configuration channel, raw_mode register
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data   // raw_mode
);

    cld_pkg::cld_cmd_t  cmd;
    cld_pkg::cld_stat_t stat;

    logic [cld_pkg::BYTE_W-1:0] out_data;
    logic [cld_pkg::LEN_W-1:0]  out_len;

    // the mode register takes a write in any cycle outside reset
    assign cfg_ready = aresetn;

    // sequencer: one key byte at a time, one output beat per cycle when free
    cld_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .stat     (stat),
        .cmd      (cmd)
    );

    // edit line storage, fill index, and the output register that parts the sides
    cld_datapath #(
        .LINE_BYTES (LINE_BYTES)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .key_in    (s_tdata),
        .cfg_we    (cfg_valid),
        .cfg_raw   (cfg_data),
        .cmd       (cmd),
        .stat      (stat),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .out_kind  (m_tuser),
        .out_data  (out_data),
        .out_len   (out_len),
        .out_last  (m_tlast)
    );

    // input is taken only in the idle state and outside reset
    assign s_tready = cmd.ready && aresetn;

    // pack result fields, lowest first
    assign m_tdata = {2'b00, out_len, out_data};

    // an accepted beat starts decode, so the next cycle cannot accept
    `CLD_ASSERT_NEXT(a_one_item_in_flight, aclk, aresetn, s_tvalid && s_tready, !s_tready)
    // the controller loads the output register only when it is free or draining
    `CLD_ASSERT_IMPL(a_emit_into_free_slot, aclk, aresetn, cmd.emit, stat.slot_free)
    // no result is produced while the block waits for input
    `CLD_ASSERT_IMPL(a_no_emit_when_ready, aclk, aresetn, cmd.emit, !s_tready)
    // a line end closes its item; line bytes never do
    `CLD_ASSERT_IMPL(a_end_is_last, aclk, aresetn, m_tvalid && (m_tuser == cld_pkg::KIND_END), m_tlast)
    `CLD_ASSERT_IMPL(a_line_not_last, aclk, aresetn, m_tvalid && (m_tuser == cld_pkg::KIND_LINE), !m_tlast)

endmodule

FILE: sim/tb_console_line_discipline.sv
// testbench for console_line_discipline: key beats in, console beats checked in order
// keeps its own cooked-mode line editor as the predictor; depends on cld_pkg and the rtl
`timescale 1ns / 1ps

module tb_console_line_discipline;

    localparam int LINE_BYTES = 32;
    localparam int LONG_HOLD  = 400;
    localparam int SETTLE     = 48;

    typedef struct packed {
        logic [cld_pkg::KIND_W-1:0] kind;
        logic [cld_pkg::BYTE_W-1:0] data_byte;
        logic [cld_pkg::LEN_W-1:0]  line_length;
        logic                       last;
    } console_beat_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;     // [7:0] data_byte, [13:8] line_length, [15:14] zero
    logic [2:0]  m_tuser;     // [2:0] kind
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_data = 1'b0;

    console_line_discipline #(
        .LINE_BYTES(LINE_BYTES)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // predictor state: edit line, fill count and the raw mode copy
    logic [7:0] edit_line [LINE_BYTES];
    int         edit_fill = 0;
    bit         raw_sel = 1'b0;

    logic [7:0]    key_pending[$];
    console_beat_t console_out_q[$];

    int keys_queued = 0;
    int keys_sent = 0;
    int beats_checked = 0;
    int cfg_writes = 0;
    int fail_count = 0;

    bit calm = 1'b0;
    bit hold_request = 1'b0;
    bit hold_active = 1'b0;
    bit hold_done = 1'b0;

    function automatic console_beat_t mk_beat(input logic [2:0] kind, input logic [7:0] data,
                                              input int len);
        console_beat_t b;
        b.kind        = kind;
        b.data_byte   = data;
        b.line_length = cld_pkg::LEN_W'(len);
        b.last        = 1'b0;
        return b;
    endfunction

    // cooked-mode editing of one key, appends the console beats it causes
    function automatic void cook_key(input logic [7:0] key);
        console_beat_t beats[$];
        console_beat_t b;
        logic [7:0]    ch;
        bit            commit;
        int            i;
        ch = key;
        commit = 1'b0;
        if (raw_sel) begin
            beats.push_back(mk_beat(cld_pkg::KIND_RAW, ch, 0));
        end else begin
            case (ch) inside
                cld_pkg::KEY_NUL: begin
                    commit = (edit_fill > 0);
                end
                cld_pkg::KEY_DEL, cld_pkg::KEY_BS: begin
                    // erase on an empty line is silent
                    if (edit_fill > 0) begin
                        edit_fill--;
                        beats.push_back(mk_beat(cld_pkg::KIND_ECHO, cld_pkg::KEY_BS, 0));
                        beats.push_back(mk_beat(cld_pkg::KIND_ECHO, cld_pkg::ECHO_SPACE, 0));
                        beats.push_back(mk_beat(cld_pkg::KIND_ECHO, cld_pkg::KEY_BS, 0));
                    end
                end
                cld_pkg::KEY_KILL: begin
                    edit_fill = 0;
                    beats.push_back(mk_beat(cld_pkg::KIND_ECHO, cld_pkg::ECHO_CARET, 0));
                    beats.push_back(mk_beat(cld_pkg::KIND_ECHO, cld_pkg::ECHO_U, 0));
                    beats.push_back(mk_beat(cld_pkg::KIND_ECHO, cld_pkg::KEY_LF, 0));
                end
                cld_pkg::KEY_QUIT: begin
                    beats.push_back(mk_beat(cld_pkg::KIND_QUIT, 8'h00, 0));
                end
                cld_pkg::KEY_EOF: begin
                    commit = 1'b1;
                end
                default: begin
                    if (ch == cld_pkg::KEY_CR) ch = cld_pkg::KEY_LF;
                    if (ch == cld_pkg::KEY_LF) commit = 1'b1;
                    if (edit_fill < LINE_BYTES) begin
                        edit_line[edit_fill] = ch;
                        edit_fill++;
                    end
                    beats.push_back(mk_beat(cld_pkg::KIND_ECHO, ch, 0));
                end
            endcase
            // a full line commits right after the echo of its last byte
            if (commit || edit_fill >= LINE_BYTES) begin
                for (i = 0; i < edit_fill; i++)
                    beats.push_back(mk_beat(cld_pkg::KIND_LINE, edit_line[i], 0));
                beats.push_back(mk_beat(cld_pkg::KIND_END, 8'h00, edit_fill));
                edit_fill = 0;
            end
        end
        for (i = 0; i < beats.size(); i++) begin
            b = beats[i];
            b.last = (i == beats.size() - 1);
            console_out_q.push_back(b);
        end
    endfunction

    // key driver: presents the head of key_pending, predicts on each accepted beat
    int src_gap_left = 0;
    int src_mode_left = 0;
    bit src_bursty = 1'b1;

    always @(posedge aclk) begin : key_driver
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= 8'h00;
        end else begin
            if (s_tvalid && s_tready) begin
                cook_key(key_pending.pop_front());
                keys_sent++;
            end
            if (src_mode_left == 0) begin
                src_bursty = ($urandom_range(0, 2) != 0);
                src_mode_left = $urandom_range(40, 300);
            end else begin
                src_mode_left--;
            end
            if (s_tvalid && !s_tready) begin
                // hold the offered beat
            end else if (src_gap_left > 0) begin
                src_gap_left--;
                s_tvalid <= 1'b0;
            end else if (!calm && !hold_active && src_bursty && $urandom_range(0, 6) == 0) begin
                src_gap_left = $urandom_range(0, 13);
                s_tvalid <= 1'b0;
            end else if (key_pending.size() > 0) begin
                s_tvalid <= 1'b1;
                s_tdata  <= key_pending[0];
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // console sink: checks each accepted beat, drives m_tready with stalls
    int sink_stall_left = 0;
    int sink_mode_left = 0;
    bit sink_bursty = 1'b1;
    int hold_cycles = 0;

    always @(posedge aclk) begin : console_sink
        console_beat_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                beats_checked++;
                if (console_out_q.size() == 0) begin
                    $error("unexpected console beat: kind %0d data_byte %02h",
                           m_tuser, m_tdata[7:0]);
                    fail_count++;
                end else begin
                    want = console_out_q.pop_front();
                    if (m_tuser !== want.kind) begin
                        $error("kind: expected %0d, actual %0d", want.kind, m_tuser);
                        fail_count++;
                    end
                    if (m_tdata[7:0] !== want.data_byte) begin
                        $error("data_byte: expected %02h, actual %02h",
                               want.data_byte, m_tdata[7:0]);
                        fail_count++;
                    end
                    if (m_tdata[13:8] !== want.line_length) begin
                        $error("line_length: expected %0d, actual %0d",
                               want.line_length, m_tdata[13:8]);
                        fail_count++;
                    end
                    if (m_tlast !== want.last) begin
                        $error("last: expected %0d, actual %0d", want.last, m_tlast);
                        fail_count++;
                    end
                end
            end
            if (sink_mode_left == 0) begin
                sink_bursty = ($urandom_range(0, 2) != 0);
                sink_mode_left = $urandom_range(40, 300);
            end else begin
                sink_mode_left--;
            end
            if (hold_request && !hold_done) begin
                // long back-pressure so the block fills and stalls its input
                if (hold_cycles < LONG_HOLD) begin
                    hold_cycles++;
                    hold_active = 1'b1;
                    m_tready <= 1'b0;
                end else begin
                    hold_done = 1'b1;
                    hold_active = 1'b0;
                    m_tready <= 1'b1;
                end
            end else if (sink_stall_left > 0) begin
                sink_stall_left--;
                m_tready <= 1'b0;
            end else if (!calm && sink_bursty && $urandom_range(0, 5) == 0) begin
                sink_stall_left = $urandom_range(0, 13);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic queue_key(input logic [7:0] k);
        key_pending.push_back(k);
        keys_queued++;
    endtask

    // one edited line with random content, mostly well formed
    task automatic add_cooked_line();
        int len;
        int i;
        int pick;
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 4)) queue_key(8'($urandom_range(0, 255)));
        end else begin
            len = ($urandom_range(0, 6) == 0) ? $urandom_range(LINE_BYTES - 4, LINE_BYTES + 2)
                                              : $urandom_range(0, 10);
            for (i = 0; i < len; i++) begin
                pick = $urandom_range(0, 39);
                if (pick < 28)      queue_key(8'($urandom_range(32, 126)));
                else if (pick < 33) queue_key(8'($urandom_range(0, 255)));
                else if (pick < 37) queue_key(($urandom_range(0, 1) != 0) ? cld_pkg::KEY_DEL
                                                                           : cld_pkg::KEY_BS);
                else if (pick < 39) queue_key(cld_pkg::KEY_QUIT);
                else                queue_key(cld_pkg::KEY_KILL);
            end
            pick = $urandom_range(0, 9);
            if (pick < 4)       queue_key(cld_pkg::KEY_LF);
            else if (pick < 6)  queue_key(cld_pkg::KEY_CR);
            else if (pick == 6) queue_key(cld_pkg::KEY_EOF);
            else if (pick == 7) queue_key(cld_pkg::KEY_NUL);
        end
    endtask

    task automatic fill_cooked(input int n);
        int start;
        start = keys_queued;
        while (keys_queued - start < n) add_cooked_line();
    endtask

    task automatic fill_raw(input int n);
        repeat (n) queue_key(8'($urandom_range(0, 255)));
    endtask

    // wait for every key to go in and every console beat to come out
    task automatic drain();
        @(posedge aclk);
        while (key_pending.size() != 0 || s_tvalid || console_out_q.size() != 0)
            @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_raw_mode(input bit mode);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= mode;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        raw_sel = mode;
        cfg_writes++;
    endtask

    initial begin : run_phases
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        write_raw_mode(1'b0);
        // erase and nul on an empty line, end of file on an empty line
        queue_key(cld_pkg::KEY_DEL);
        queue_key(cld_pkg::KEY_NUL);
        queue_key(cld_pkg::KEY_EOF);
        // carriage return commits as newline
        queue_key("h");
        queue_key("i");
        queue_key(cld_pkg::KEY_CR);
        // quit keeps the line, then nul commits it
        queue_key("x");
        queue_key(cld_pkg::KEY_QUIT);
        queue_key(cld_pkg::KEY_NUL);
        // both erase codes and kill
        queue_key("a");
        queue_key(cld_pkg::KEY_BS);
        queue_key("b");
        queue_key(cld_pkg::KEY_DEL);
        queue_key("c");
        queue_key(cld_pkg::KEY_KILL);
        // byte extremes, end of file on a non-empty line, newline
        queue_key(8'hff);
        queue_key(8'h80);
        queue_key(8'h01);
        queue_key(cld_pkg::KEY_EOF);
        queue_key("z");
        queue_key(cld_pkg::KEY_LF);
        drain();

        // raw mode passes control bytes through
        write_raw_mode(1'b1);
        queue_key(cld_pkg::KEY_NUL);
        queue_key(8'hff);
        queue_key(cld_pkg::KEY_DEL);
        queue_key(cld_pkg::KEY_KILL);
        queue_key(cld_pkg::KEY_CR);
        queue_key(cld_pkg::KEY_QUIT);
        queue_key(cld_pkg::KEY_EOF);
        drain();

        write_raw_mode(1'b0);
        fill_cooked(170);
        drain();

        // a partial line may be pending here; raw mode must leave it alone
        write_raw_mode(1'b1);
        fill_raw(50);
        drain();

        write_raw_mode(1'b0);
        hold_request = 1'b1;
        fill_cooked(140);
        drain();

        write_raw_mode(1'b1);
        fill_raw(30);
        drain();

        // closing stretch without idling on either side
        write_raw_mode(1'b0);
        calm = 1'b1;
        fill_cooked(80);
        drain();

        if (console_out_q.size() != 0) begin
            $error("%0d console beats never arrived", console_out_q.size());
            fail_count++;
        end
        $display("covered %0d key beats, %0d console beats, %0d raw mode writes",
                 keys_sent, beats_checked, cfg_writes);
        $display("cooked and raw phases with erase, kill, quit, commit and full-line cases");
        if (fail_count == 0) begin
            $display("tb_console_line_discipline: PASS");
        end else begin
            $display("tb_console_line_discipline: FAIL");
        end
        $finish;
    end

    initial begin : watchdog
        #(64'd10_000_000);
        $display("tb_console_line_discipline: FAIL");
        $finish;
    end

endmodule
